// File: src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the reverse Polish notation evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] FILL_RESET = 32'sd2752512;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOD   = 4'd5,
    OP_TOP   = 4'd6,
    OP_DUP   = 4'd7,
    OP_SWAP  = 4'd8,
    OP_CLEAR = 4'd9,
    OP_POP   = 4'd10
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_MOD_ZERO  = 3'd4,
    ST_SATURATED = 3'd5,
    ST_TOO_FEW   = 3'd6,
    ST_HALTED    = 3'd7
  } status_t;

  // per-cycle move applied to every cell of the stack
  typedef enum logic [2:0] {
    CMD_NOP     = 3'd0,
    CMD_PUSH    = 3'd1,
    CMD_POP     = 3'd2,
    CMD_REPL    = 3'd3,
    CMD_POPREPL = 3'd4,
    CMD_SWAP    = 3'd5
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [DATA_W-1:0]   data;
  } cell_ctrl_t;

endpackage

// File: src/rpn_cell.sv
// ----------------------------------------------------------------------------
// rpn_cell
// One stack entry; takes its neighbor's value on push, pop and swap moves.
// ----------------------------------------------------------------------------
module rpn_cell (
  input  logic                        clk,
  input  rpn_pkg::cell_cmd_t          cmd,
  input  logic                        is_top,
  input  logic                        is_second,
  input  logic [rpn_pkg::DATA_W-1:0]  above,
  input  logic [rpn_pkg::DATA_W-1:0]  below,
  output logic [rpn_pkg::DATA_W-1:0]  q
);

  always_ff @(posedge clk) begin
    unique case (cmd)
      rpn_pkg::CMD_NOP: begin
        q <= q;
      end
      rpn_pkg::CMD_PUSH: begin
        q <= above;
      end
      rpn_pkg::CMD_POP: begin
        q <= below;
      end
      rpn_pkg::CMD_REPL: begin
        if (is_top) begin
          q <= above;
        end
      end
      rpn_pkg::CMD_POPREPL: begin
        q <= is_top ? above : below;
      end
      rpn_pkg::CMD_SWAP: begin
        if (is_top) begin
          q <= below;
        end else if (is_second) begin
          q <= above;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// File: src/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rpn_pkg::DIV_W-1:0]   dividend,
  input  logic [rpn_pkg::DATA_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [rpn_pkg::DIV_W-1:0]   quotient,
  output logic [rpn_pkg::DATA_W-1:0]  remainder
);

  localparam logic [rpn_pkg::DIV_CNT_W-1:0] LAST_STEP =
    rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_W - 1);

  logic [rpn_pkg::DIV_CNT_W-1:0] cnt;
  logic [rpn_pkg::DATA_W-1:0]    dvsr;
  logic [rpn_pkg::DATA_W:0]      rem_sh;
  logic [rpn_pkg::DATA_W:0]      rem_sub;
  logic                          ge;

  assign rem_sh  = {remainder, quotient[rpn_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvsr};
  assign rem_sub = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (busy) begin
      remainder <= ge ? rem_sub[rpn_pkg::DATA_W-1:0] : rem_sh[rpn_pkg::DATA_W-1:0];
      quotient  <= {quotient[rpn_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

// File: src/rpn_stack_evaluator.sv
// A request is captured in S_IDLE and decoded in S_EXEC; stack ops, add, sub,
// halted requests and a div or mod by zero commit from S_EXEC, mul from S_MUL
// after its product is registered, and div and mod from S_FIN after the 48-step
// divider in S_DIV. One request at a time; a stalled result holds the next one.
// Reset (synchronous, rst high): empty stack, halt released, empty_fill = 42.0.
// Stack entries are not cleared; entries above the depth are never read.
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Q16.16 operand stack built as a chain of shifting cells, with an iterative
// divider for div and mod.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] top_value,
  output logic signed [31:0] second_value,
  output logic [7:0]         depth,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam int unsigned W = rpn_pkg::DATA_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [SPW-1:0]         sp, sp_next;
  logic                   halted, halted_next;
  logic signed [W-1:0]    empty_fill;
  rpn_pkg::opcode_t       op;
  logic [W-1:0]           val;
  logic signed [63:0]     prod;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : empty_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_fill <= rpn_pkg::FILL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      empty_fill <= pwdata;
    end
  end

  // cell chain
  rpn_pkg::cell_ctrl_t ctrl;
  logic [W-1:0] cells [0:STACK_DEPTH];

  assign cells[STACK_DEPTH] = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rpn_cell u_cell (
      .clk      (clk),
      .cmd      (ctrl.cmd),
      .is_top   (i == 0),
      .is_second(i == 1),
      .above    ((i == 0) ? ctrl.data : cells[(i == 0) ? 0 : i - 1]),
      .below    (cells[i + 1]),
      .q        (cells[i])
    );
  end

  logic [W-1:0] c0, c1, c2;
  assign c0 = cells[0];
  assign c1 = cells[1];
  assign c2 = cells[2];

  // operands as the stack pops them, with empty_fill for missing entries
  logic              sp_ge1, sp_ge2, sp_full, uf;
  logic signed [W-1:0] a, b;
  logic [W-1:0]      a_mag, b_mag;

  assign sp_ge1  = sp != '0;
  assign sp_ge2  = sp > SPW'(1);
  assign sp_full = sp == SP_FULL;
  assign b       = sp_ge1 ? c0 : empty_fill;
  assign a       = sp_ge2 ? c1 : empty_fill;
  assign uf      = !sp_ge2;
  assign a_mag   = a[W-1] ? W'(-a) : W'(a);
  assign b_mag   = b[W-1] ? W'(-b) : W'(b);

  // add / sub
  logic signed [W:0] sum, diff;
  assign sum  = {a[W-1], a} + {b[W-1], b};
  assign diff = {a[W-1], a} - {b[W-1], b};

  // mul, product registered in S_EXEC
  logic          mul_sat;
  logic [W-1:0]  mul_r;
  assign mul_sat = !((&prod[63:47]) || !(|prod[63:47]));
  assign mul_r   = mul_sat ? (prod[63] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX) : prod[47:16];

  // divider
  logic                     div_start, div_busy, div_done;
  logic [rpn_pkg::DIV_W-1:0] div_q;
  logic [W-1:0]             div_rem;
  logic                     is_div, zero_div;

  assign is_div   = op == rpn_pkg::OP_DIV;
  assign zero_div = is_div ? (b == '0) : (b_mag[W-1:16] == '0);

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (is_div ? {a_mag, 16'b0} : {32'b0, a_mag[W-1:16]}),
    .divisor  (is_div ? b_mag : {16'b0, b_mag[W-1:16]}),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  logic          q_neg, div_sat;
  logic [W-1:0]  div_r, mod_mag, mod_r;
  assign q_neg   = a[W-1] ^ b[W-1];
  assign div_sat = q_neg ? (div_q > 48'h0000_8000_0000) : (div_q > 48'h0000_7fff_ffff);
  assign div_r   = div_sat ? (q_neg ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX)
                           : (q_neg ? W'(-div_q[W-1:0]) : div_q[W-1:0]);
  assign mod_mag = {div_rem[15:0], 16'b0};
  assign mod_r   = a[W-1] ? W'(-mod_mag) : mod_mag;

  // step decode
  logic              slot_free, commit;
  rpn_pkg::status_t  st;
  logic [W-1:0]      res, popped, n0, n1;
  logic              is_pop;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    ctrl.cmd    = rpn_pkg::CMD_NOP;
    ctrl.data   = '0;
    sp_next     = sp;
    halted_next = halted;
    st          = rpn_pkg::ST_OK;
    res         = '0;
    is_pop      = 1'b0;
    popped      = b;
    commit      = 1'b0;
    div_start   = 1'b0;
    state_next  = state;

    unique case (op)
      rpn_pkg::OP_ADD: res = (sum[W] != sum[W-1]) ? (sum[W] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX)
                                                   : sum[W-1:0];
      rpn_pkg::OP_SUB: res = (diff[W] != diff[W-1]) ? (diff[W] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX)
                                                     : diff[W-1:0];
      rpn_pkg::OP_MUL: res = mul_r;
      rpn_pkg::OP_DIV: res = div_r;
      rpn_pkg::OP_MOD: res = mod_r;
      default:         res = '0;
    endcase

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!halted && op == rpn_pkg::OP_MUL) begin
          state_next = S_MUL;
        end else if (!halted && (op == rpn_pkg::OP_DIV || op == rpn_pkg::OP_MOD)
                     && !zero_div) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (slot_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL, S_FIN: begin
        if (slot_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (halted && op != rpn_pkg::OP_CLEAR) begin
      st = rpn_pkg::ST_HALTED;
    end else begin
      unique case (op)
        rpn_pkg::OP_PUSH: begin
          if (sp_full) begin
            st = rpn_pkg::ST_OVERFLOW;
          end else begin
            ctrl.cmd  = rpn_pkg::CMD_PUSH;
            ctrl.data = val;
            sp_next   = sp + 1'b1;
          end
        end
        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
        rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
          if ((op == rpn_pkg::OP_DIV || op == rpn_pkg::OP_MOD) && zero_div) begin
            // divisor is consumed and the evaluator halts; nothing else happens
            ctrl.cmd    = sp_ge1 ? rpn_pkg::CMD_POP : rpn_pkg::CMD_NOP;
            sp_next     = sp_ge1 ? sp - 1'b1 : sp;
            halted_next = 1'b1;
            st          = is_div ? rpn_pkg::ST_DIV_ZERO : rpn_pkg::ST_MOD_ZERO;
          end else begin
            ctrl.cmd  = sp_ge2 ? rpn_pkg::CMD_POPREPL : rpn_pkg::CMD_REPL;
            ctrl.data = res;
            sp_next   = sp_ge2 ? sp - 1'b1 : SPW'(1);
            if (uf) begin
              st = rpn_pkg::ST_UNDERFLOW;
            end else if (res == rpn_pkg::SAT_MAX || res == rpn_pkg::SAT_MIN) begin
              // saturation shows as a clamped value only when it really clamped
              priority case (op)
                rpn_pkg::OP_ADD: st = (sum[W] != sum[W-1]) ? rpn_pkg::ST_SATURATED
                                                          : rpn_pkg::ST_OK;
                rpn_pkg::OP_SUB: st = (diff[W] != diff[W-1]) ? rpn_pkg::ST_SATURATED
                                                            : rpn_pkg::ST_OK;
                rpn_pkg::OP_MUL: st = mul_sat ? rpn_pkg::ST_SATURATED : rpn_pkg::ST_OK;
                rpn_pkg::OP_DIV: st = div_sat ? rpn_pkg::ST_SATURATED : rpn_pkg::ST_OK;
                default:         st = rpn_pkg::ST_OK;
              endcase
            end
          end
        end
        rpn_pkg::OP_DUP: begin
          if (!sp_ge1) begin
            st = rpn_pkg::ST_TOO_FEW;
          end else if (sp_full) begin
            st = rpn_pkg::ST_OVERFLOW;
          end else begin
            ctrl.cmd  = rpn_pkg::CMD_PUSH;
            ctrl.data = c0;
            sp_next   = sp + 1'b1;
          end
        end
        rpn_pkg::OP_SWAP: begin
          if (!sp_ge2) begin
            st = rpn_pkg::ST_TOO_FEW;
          end else begin
            ctrl.cmd = rpn_pkg::CMD_SWAP;
          end
        end
        rpn_pkg::OP_CLEAR: begin
          sp_next     = '0;
          halted_next = 1'b0;
        end
        rpn_pkg::OP_POP: begin
          is_pop   = 1'b1;
          ctrl.cmd = sp_ge1 ? rpn_pkg::CMD_POP : rpn_pkg::CMD_NOP;
          sp_next  = sp_ge1 ? sp - 1'b1 : sp;
          if (!sp_ge1) begin
            st = rpn_pkg::ST_UNDERFLOW;
          end
        end
        default: st = rpn_pkg::ST_OK;
      endcase
    end

    if (!commit) begin
      ctrl.cmd    = rpn_pkg::CMD_NOP;
      sp_next     = sp;
      halted_next = halted;
    end
  end

  // top two entries after the move
  always_comb begin
    unique case (ctrl.cmd)
      rpn_pkg::CMD_PUSH:    begin n0 = ctrl.data; n1 = c0; end
      rpn_pkg::CMD_POP:     begin n0 = c1;        n1 = c2; end
      rpn_pkg::CMD_REPL:    begin n0 = ctrl.data; n1 = c1; end
      rpn_pkg::CMD_POPREPL: begin n0 = ctrl.data; n1 = c2; end
      rpn_pkg::CMD_SWAP:    begin n0 = c1;        n1 = c0; end
      default:              begin n0 = c0;        n1 = c1; end
    endcase
  end

  assign in_stall = state != S_IDLE;

  logic [SPW+7:0] sp_ext;
  assign sp_ext = {8'b0, sp_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      halted <= halted_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op  <= rpn_pkg::opcode_t'(opcode);
      val <= value;
    end
    if (state == S_EXEC) begin
      prod <= a * b;
    end
    if (commit) begin
      status <= st;
      depth  <= sp_ext[7:0];
      if (is_pop) begin
        top_value    <= popped;
        second_value <= (sp_next != '0) ? n0 : '0;
      end else begin
        top_value    <= (sp_next != '0) ? n0 : '0;
        second_value <= (sp_next > SPW'(1)) ? n1 : '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_sp_range: assert property (@(posedge clk) disable iff (rst) sp <= SP_FULL)
    else $error("stack pointer beyond depth");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
      div_busy |-> state == S_DIV)
    else $error("divider busy outside divide state");
  a_halt_hold: assert property (@(posedge clk) disable iff (rst)
      (commit && st == rpn_pkg::ST_HALTED) |=> ($stable(sp) && halted))
    else $error("halted request changed the stack");
  a_zero_halts: assert property (@(posedge clk) disable iff (rst)
      (commit && (st == rpn_pkg::ST_DIV_ZERO || st == rpn_pkg::ST_MOD_ZERO)) |=> halted)
    else $error("zero divisor did not halt");
`endif

endmodule
